// File: sv/toggle_target_move_towards_unit_assert.svh
// Assertion macros for the point mover.
`ifndef TOGGLE_TARGET_MOVE_TOWARDS_UNIT_ASSERT_SVH
`define TOGGLE_TARGET_MOVE_TOWARDS_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TTM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define TTM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/ttm_pkg.sv
// Package: types and constants for the point mover.
`default_nettype none
package ttm_pkg;
	localparam int unsigned CoordW = 32;
	localparam int unsigned SpeedW = 24;
	localparam int unsigned StepW = 20;
	localparam int unsigned SqW = 67;
	localparam int unsigned RootW = 34;
	localparam int unsigned ProdW = 52;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned TicksPerSec = 60;
	localparam logic [SpeedW-1:0] SpeedReset = 24'd65536;

	// floor(x / 60) == (x * StepRecip) >> StepShift for every x below 2^25
	localparam int unsigned RecipW = 26;
	localparam int unsigned StepShift = 31;
	localparam logic [RecipW-1:0] StepRecip = 26'd35791395;

	localparam logic [CfgIdxW-1:0] REG_HOME_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HOME_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_HOME_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TGT_X = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TGT_Y = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TGT_Z = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPEED = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STEP, ST_SQ, ST_CMP, ST_ROOT, ST_MUL, ST_DIV, ST_ADV, ST_OUT
	} state_t;

	// Control to the shared divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;
endpackage
`default_nettype wire

// File: sv/toggle_target_move_towards_unit.sv
// Top level of the constant-speed 3D point mover.
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | func, is_on
// out     | out | out_valid / out_ready | pos_x..z, vel_x..z
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Acceptance to result valid: a place goes straight to the output state; a snap
// runs step, squared distance over three axes, compare and output; an advance also
// runs the bit-serial root and, per axis, multiply, divide through the one shared
// divider and update. in_ready is high only in idle, so the next item can be taken
// in the cycle after the result is registered. Reset clears the position, home and
// target registers and control and presets the speed. A result not yet taken holds
// in the output registers; only the next result waits for it, in the output state.
`default_nettype none
`include "toggle_target_move_towards_unit_assert.svh"
module toggle_target_move_towards_unit import ttm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                func,
	input  wire logic                is_on,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [CoordW-1:0] pos_x,
	output logic signed [CoordW-1:0] pos_y,
	output logic signed [CoordW-1:0] pos_z,
	output logic signed [CoordW-1:0] vel_x,
	output logic signed [CoordW-1:0] vel_y,
	output logic signed [CoordW-1:0] vel_z,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CoordW-1:0]   cfg_data
);
	localparam int unsigned NumW = ProdW;
	localparam int unsigned StepProdW = SpeedW + 1 + RecipW;

	state_t st_q, st_d;
	logic signed [CoordW-1:0] home_q [3];
	logic signed [CoordW-1:0] tgt_q [3];
	logic [SpeedW-1:0] speed_q;
	logic signed [CoordW-1:0] cur_q [3];
	logic signed [CoordW-1:0] old_q [3];
	logic signed [CoordW:0] diff_q [3];     // goal - cur, 33 bits
	logic [StepW-1:0] step_q;
	logic [SqW-1:0] acc_q;                   // squared distance
	logic [RootW-1:0] root_q;
	logic [SqW+1:0] rrem_q;                  // root remainder
	logic [SqW:0] rrad_q;                    // radicand shift register
	logic [5:0] cnt_q;
	logic [1:0] ax_q;
	logic on_q;
	logic [NumW-1:0] prod_q;
	logic div_busy;
	logic [NumW-1:0] div_quo;
	div_ctl_t dctl;
	logic div_run_q;
	logic outv_q;
	logic out_free;
	logic signed [CoordW-1:0] pos_o [3];
	logic signed [CoordW-1:0] vel_o [3];

	// per-axis shared datapath
	logic signed [CoordW:0] d_sel;
	logic [CoordW:0] mag;
	logic [2*CoordW+1:0] sq;
	logic [SpeedW:0] sp2;
	logic [StepProdW-1:0] stp_prod;
	logic [2*StepW-1:0] step_sq;
	logic snap;
	logic [SqW+1:0] rtrial;
	logic signed [CoordW+1:0] nxt;
	logic signed [CoordW+1:0] vdif [3];
	logic signed [CoordW-1:0] vsat [3];
	logic [NumW-1:0] qmag;

	assign d_sel = diff_q[ax_q];
	assign mag = d_sel[CoordW] ? -d_sel : d_sel;
	assign sq = (2*CoordW+2)'(mag) * (2*CoordW+2)'(mag);
	assign sp2 = on_q ? {speed_q, 1'b0} : {1'b0, speed_q};
	// step = sp2 / 60 by reciprocal multiply
	assign stp_prod = StepProdW'(sp2) * StepProdW'(StepRecip);
	assign step_sq = (2*StepW)'(step_q) * (2*StepW)'(step_q);
	assign snap = (acc_q <= SqW'(step_sq));
	assign rtrial = {rrem_q[SqW-1:0], rrad_q[SqW:SqW-1]} - {33'd0, root_q, 2'b01};
	assign qmag = div_quo;
	// output registers free once the last result is gone or leaving now
	assign out_free = !outv_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			home_q <= '{default: '0};
			tgt_q <= '{default: '0};
			speed_q <= SpeedReset;
			cur_q <= '{default: '0};
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_HOME_X: home_q[0] <= cfg_data;
					REG_HOME_Y: home_q[1] <= cfg_data;
					REG_HOME_Z: home_q[2] <= cfg_data;
					REG_TGT_X:  tgt_q[0] <= cfg_data;
					REG_TGT_Y:  tgt_q[1] <= cfg_data;
					REG_TGT_Z:  tgt_q[2] <= cfg_data;
					REG_SPEED:  speed_q <= cfg_data[SpeedW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready && func) begin
				cur_q <= home_q;
			end else if (st_q == ST_CMP && snap) begin
				for (int i = 0; i < 3; i++) begin
					cur_q[i] <= on_q ? tgt_q[i] : home_q[i];
				end
			end else if (st_q == ST_ADV) begin
				cur_q[ax_q] <= nxt[CoordW-1:0];
			end
		end
	end

	// next position for one axis: quotient carries the sign of diff
	always_comb begin
		nxt = {{2{cur_q[ax_q][CoordW-1]}}, cur_q[ax_q]}
			+ (d_sel[CoordW] ? -$signed({2'b00, qmag[CoordW-1:0]})
				: $signed({2'b00, qmag[CoordW-1:0]}));
	end

	// per-tick change, saturated to 32 bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vdif[i] = $signed({{2{cur_q[i][CoordW-1]}}, cur_q[i]})
				- $signed({{2{old_q[i][CoordW-1]}}, old_q[i]});
			if (vdif[i] > 34'sh07FFFFFFF) vsat[i] = 32'sh7FFFFFFF;
			else if (vdif[i] < -34'sh080000000) vsat[i] = 32'sh80000000;
			else vsat[i] = vdif[i][CoordW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					on_q <= is_on;
					ax_q <= '0;
					acc_q <= '0;
					for (int i = 0; i < 3; i++) begin
						// a place compares home with home: zero change
						old_q[i] <= func ? home_q[i] : cur_q[i];
						diff_q[i] <= $signed({(is_on ? tgt_q[i][CoordW-1] : home_q[i][CoordW-1]),
							(is_on ? tgt_q[i] : home_q[i])})
							- $signed({cur_q[i][CoordW-1], cur_q[i]});
					end
				end
			end
			ST_STEP: begin
				step_q <= stp_prod[StepShift +: StepW];
			end
			ST_SQ: begin
				acc_q <= acc_q + SqW'(sq);
				ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				root_q <= '0;
				rrem_q <= '0;
				cnt_q <= 6'(RootW);
			end
			ST_CMP: begin
				rrad_q <= {1'b0, acc_q};
			end
			ST_ROOT: begin
				cnt_q <= cnt_q - 6'd1;
				rrad_q <= {rrad_q[SqW-2:0], 2'b00};
				if (!rtrial[SqW+1]) begin
					rrem_q <= rtrial;
					root_q <= {root_q[RootW-2:0], 1'b1};
				end else begin
					rrem_q <= {rrem_q[SqW-1:0], rrad_q[SqW:SqW-1]};
					root_q <= {root_q[RootW-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				prod_q <= NumW'(mag) * NumW'(step_q);
			end
			ST_DIV: ;
			ST_ADV: begin
				ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					for (int i = 0; i < 3; i++) begin
						pos_o[i] <= cur_q[i];
						vel_o[i] <= vsat[i];
					end
				end
			end
			default: ;
		endcase
	end

	ttm_div #(.NumW(NumW), .DenW(RootW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl),
		.num(prod_q), .den(root_q), .busy(div_busy), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) outv_q <= 1'b0;
		else if (st_q == ST_OUT && out_free) outv_q <= 1'b1;
		else if (out_valid && out_ready) outv_q <= 1'b0;
	end

	always_comb begin
		st_d = st_q;
		dctl = '{start: 1'b0};
		unique case (st_q)
			ST_IDLE: if (in_valid && in_ready) st_d = func ? ST_OUT : ST_STEP;
			ST_STEP: st_d = ST_SQ;
			ST_SQ:   if (ax_q == 2'd2) st_d = ST_CMP;
			ST_CMP:  st_d = snap ? ST_OUT : ST_ROOT;
			ST_ROOT: if (cnt_q == 6'd1) st_d = ST_MUL;
			ST_MUL:  st_d = ST_DIV;
			ST_DIV:  begin
				dctl.start = !div_run_q;
				if (div_run_q && !div_busy) st_d = ST_ADV;
			end
			ST_ADV:  st_d = (ax_q == 2'd2) ? ST_OUT : ST_MUL;
			ST_OUT:  if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// high from divider start until the quotient has been used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_run_q <= 1'b0;
		else div_run_q <= dctl.start || (div_run_q && st_q == ST_DIV);
	end

	assign in_ready = (st_q == ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE);
	assign out_valid = outv_q;
	assign pos_x = pos_o[0];
	assign pos_y = pos_o[1];
	assign pos_z = pos_o[2];
	assign vel_x = vel_o[0];
	assign vel_y = vel_o[1];
	assign vel_z = vel_o[2];

	`TTM_ASSERT_IMP(a_busy_not_ready, st_q != ST_IDLE, !in_ready)
	`TTM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(vel_x))
	`TTM_ASSERT_NXT(a_place_out, in_valid && in_ready && func, st_q == ST_OUT)
endmodule
`default_nettype wire

// File: sv/ttm_div.sv
// Restoring divider: unsigned 52-bit dividend by 34-bit divisor, one bit a cycle.
`default_nettype none
module ttm_div import ttm_pkg::*; #(
	parameter int unsigned NumW = ProdW,
	parameter int unsigned DenW = RootW
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire div_ctl_t        ctl,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output logic                 busy,
	output logic [NumW-1:0]      quo
);
	localparam int unsigned CntW = $clog2(NumW + 1);
	logic [NumW-1:0] quo_q;
	logic [DenW:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW+1:0] trial;

	assign trial = {rem_q, quo_q[NumW-1]} - {2'b00, den};
	assign busy = (cnt_q != '0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[DenW+1]) begin
				rem_q <= trial[DenW:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DenW-1:0], quo_q[NumW-1]};
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire
